/* sv/stdrc_pkg.sv */
`timescale 1ns / 1ps

package stdrc_pkg;

    localparam int ID_W         = 32;
    localparam int CNT_W        = 32;
    localparam int DEF_ID_BITS  = 32;
    localparam int MAX_RECS     = 5;
    localparam int REC_IDX_W    = $clog2(MAX_RECS);
    localparam int REC_CNT_W    = $clog2(MAX_RECS + 1);

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_KEY    = 2'd1,
        KIND_PAIR   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [ID_W-1:0] subject_id;
        logic [ID_W-1:0] predicate_id;
        logic [ID_W-1:0] object_id;
        logic [ID_W-1:0] time_id;
        logic            first_item;
        logic            last_item;
    } t_item;

    typedef struct packed {
        t_kind            record_kind;
        logic [ID_W-1:0]  out_subject;
        logic [ID_W-1:0]  out_predicate;
        logic [ID_W-1:0]  out_object;
        logic [ID_W-1:0]  out_time;
        logic [CNT_W-1:0] run_count;
    } t_rec;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (&c) ? c : c + CNT_W'(1);
    endfunction

endpackage

/* sv/stdrc_item_if.sv */
`timescale 1ns / 1ps

interface stdrc_item_if;
    import stdrc_pkg::*;

    logic            valid;
    logic            ready;
    logic [ID_W-1:0] subject_id;
    logic [ID_W-1:0] predicate_id;
    logic [ID_W-1:0] object_id;
    logic [ID_W-1:0] time_id;
    logic            first_item;
    logic            last_item;

    modport source (
        output valid, subject_id, predicate_id, object_id, time_id, first_item, last_item,
        input  ready
    );
    modport sink (
        input  valid, subject_id, predicate_id, object_id, time_id, first_item, last_item,
        output ready
    );
endinterface

/* sv/stdrc_rec_if.sv */
`timescale 1ns / 1ps

interface stdrc_rec_if;
    import stdrc_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       record_kind;
    logic [ID_W-1:0]  out_subject;
    logic [ID_W-1:0]  out_predicate;
    logic [ID_W-1:0]  out_object;
    logic [ID_W-1:0]  out_time;
    logic [CNT_W-1:0] run_count;
    logic             end_of_run;

    modport source (
        output valid, record_kind, out_subject, out_predicate, out_object, out_time,
               run_count, end_of_run,
        input  ready
    );
    modport sink (
        input  valid, record_kind, out_subject, out_predicate, out_object, out_time,
               run_count, end_of_run,
        output ready
    );
endinterface

/* sv/stdrc_cfg_if.sv */
`timescale 1ns / 1ps

interface stdrc_cfg_if;
    logic valid;
    logic ready;
    logic order_mode;

    modport source (output valid, order_mode, input ready);
    modport sink   (input valid, order_mode, output ready);
endinterface

/* sv/sorted_triple_dedup_run_counter_top.sv */
`timescale 1ns / 1ps

// Sorted quad stream duplicate drop with run-length statistics. Quads arrive on
// i_item already sorted by subject (order_mode 0) or by object (order_mode 1).
// A quad equal to the last kept one (time ignored in order_mode 1) is dropped;
// otherwise per-key and per key-predicate statistics are emitted when a run
// closes, followed by an insert record, and the item marked last flushes the
// final statistics. Each request is registered, then resolved into up to five
// records held in a small record buffer that drains one record per cycle on
// o_rec while o_rec.ready is high; the next request is resolved in the cycle
// the last pending record leaves. A plain insert yields one record, and a
// dropped duplicate yields none unless it is marked last. The first record is
// driven from the record buffer after the request passes the input register.
// IDs are kept modulo 2^ID_BITS; counts saturate at all ones.
module sorted_triple_dedup_run_counter_top #(
    parameter int ID_BITS = stdrc_pkg::DEF_ID_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    stdrc_cfg_if.sink     i_cfg,
    stdrc_item_if.sink    i_item,
    stdrc_rec_if.source   o_rec
);
    import stdrc_pkg::*;

    localparam int KB = (ID_BITS < ID_W) ? ID_BITS : ID_W;

    // config
    logic r_mode;

    // input register
    logic  r_in_valid;
    t_item r_in;

    // stream state
    logic [KB-1:0]    r_ps, r_pp, r_po, r_pt;
    logic [CNT_W-1:0] r_kc, r_pc;
    logic             r_have;

    // record buffer
    t_rec                 r_rec [MAX_RECS];
    logic [REC_IDX_W-1:0] r_idx;
    logic [REC_CNT_W-1:0] r_left;

    logic proc, buf_free, out_fire;

    logic [KB-1:0]    s, p, o, t;
    logic             start, dup, key_chg, pred_chg, ins;
    logic [KB-1:0]    n_ps, n_pp, n_po, n_pt;
    logic [CNT_W-1:0] n_kc, n_pc;
    logic             n_have;
    t_rec             cand [MAX_RECS];
    logic [MAX_RECS-1:0] cand_en;
    t_rec             n_rec [MAX_RECS];
    logic [REC_CNT_W-1:0] n_cnt;

    assign i_cfg.ready  = 1'b1;
    assign out_fire     = o_rec.valid && o_rec.ready;
    assign buf_free     = (r_left == '0) ||
                          (r_left == REC_CNT_W'(1) && o_rec.ready);
    assign proc         = r_in_valid && buf_free;
    assign i_item.ready = !r_in_valid || proc;

    assign s = r_in.subject_id[KB-1:0];
    assign p = r_in.predicate_id[KB-1:0];
    assign o = r_in.object_id[KB-1:0];
    assign t = r_in.time_id[KB-1:0];

    always_comb begin
        start    = r_in.first_item || !r_have;
        dup      = !start && s == r_ps && p == r_pp && o == r_po && (r_mode || t == r_pt);
        key_chg  = !start && !dup && (r_mode ? (o != r_po) : (s != r_ps));
        pred_chg = !start && !dup && !key_chg && p != r_pp;
        ins      = !dup;

        n_ps   = ins ? s : r_ps;
        n_pp   = ins ? p : r_pp;
        n_po   = ins ? o : r_po;
        n_pt   = ins ? t : r_pt;
        n_have = r_have || ins;

        if (start || key_chg) begin
            n_kc = CNT_W'(1);
            n_pc = CNT_W'(1);
        end else if (pred_chg) begin
            n_kc = sat_inc(r_kc);
            n_pc = CNT_W'(1);
        end else if (!dup) begin
            n_kc = sat_inc(r_kc);
            n_pc = sat_inc(r_pc);
        end else begin
            n_kc = r_kc;
            n_pc = r_pc;
        end

        // closing stats of the previous runs
        cand[0] = '{KIND_KEY, r_mode ? '0 : ID_W'(r_ps), '0,
                    r_mode ? ID_W'(r_po) : '0, '0, r_kc};
        cand[1] = '{KIND_PAIR, r_mode ? '0 : ID_W'(r_ps), ID_W'(r_pp),
                    r_mode ? ID_W'(r_po) : '0, '0, r_pc};
        cand[2] = '{KIND_INSERT, ID_W'(s), ID_W'(p), ID_W'(o), ID_W'(t), '0};
        // final flush uses the state after this quad
        cand[3] = '{KIND_KEY, r_mode ? '0 : ID_W'(n_ps), '0,
                    r_mode ? ID_W'(n_po) : '0, '0, n_kc};
        cand[4] = '{KIND_PAIR, r_mode ? '0 : ID_W'(n_ps), ID_W'(n_pp),
                    r_mode ? ID_W'(n_po) : '0, '0, n_pc};

        cand_en[0] = key_chg;
        cand_en[1] = key_chg || pred_chg;
        cand_en[2] = ins;
        cand_en[3] = r_in.last_item && n_have;
        cand_en[4] = r_in.last_item && n_have;

        for (int i = 0; i < MAX_RECS; i++) begin
            n_rec[i] = cand[i];
        end
        n_cnt = '0;
        for (int i = 0; i < MAX_RECS; i++) begin
            if (cand_en[i]) begin
                n_rec[n_cnt[REC_IDX_W-1:0]] = cand[i];
                n_cnt = n_cnt + REC_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_in_valid <= 1'b0;
            r_ps       <= '0;
            r_pp       <= '0;
            r_po       <= '0;
            r_pt       <= '0;
            r_kc       <= '0;
            r_pc       <= '0;
            r_have     <= 1'b0;
            r_idx      <= '0;
            r_left     <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_mode <= i_cfg.order_mode;
            end

            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end

            if (proc) begin
                r_ps   <= n_ps;
                r_pp   <= n_pp;
                r_po   <= n_po;
                r_pt   <= n_pt;
                if (r_in.last_item) begin
                    r_have <= 1'b0;
                    r_kc   <= '0;
                    r_pc   <= '0;
                end else begin
                    r_have <= n_have;
                    r_kc   <= n_kc;
                    r_pc   <= n_pc;
                end
                r_idx  <= '0;
                r_left <= n_cnt;
            end else if (out_fire) begin
                r_idx  <= r_idx + REC_IDX_W'(1);
                r_left <= r_left - REC_CNT_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_in.subject_id   <= i_item.subject_id;
            r_in.predicate_id <= i_item.predicate_id;
            r_in.object_id    <= i_item.object_id;
            r_in.time_id      <= i_item.time_id;
            r_in.first_item   <= i_item.first_item;
            r_in.last_item    <= i_item.last_item;
        end
        if (proc) begin
            for (int i = 0; i < MAX_RECS; i++) begin
                r_rec[i] <= n_rec[i];
            end
        end
    end

    assign o_rec.valid         = r_left != '0;
    assign o_rec.record_kind   = r_rec[r_idx].record_kind;
    assign o_rec.out_subject   = r_rec[r_idx].out_subject;
    assign o_rec.out_predicate = r_rec[r_idx].out_predicate;
    assign o_rec.out_object    = r_rec[r_idx].out_object;
    assign o_rec.out_time      = r_rec[r_idx].out_time;
    assign o_rec.run_count     = r_rec[r_idx].run_count;
    assign o_rec.end_of_run    = r_left == REC_CNT_W'(1);

endmodule
